[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file rsdsb_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/rsdsb_pkg.sv]
// Types and constants for the double-size run-length sprite span blitter.
// No dependencies.
package rsdsb_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 13;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_WINDOW_LEFT  = 3'd0,
      CSR_WINDOW_TOP   = 3'd1,
      CSR_WINDOW_WIDTH = 3'd2,
      CSR_SPRITE_LEFT  = 3'd3,
      CSR_SPRITE_TOP   = 3'd4,
      CSR_SPRITE_ROWS  = 3'd5,
      CSR_DRAW_COLOUR  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [7:0] code_byte;
      logic              first_byte;
   } req_type;

   typedef struct packed {
      logic [12:0] span_row;
      logic [12:0] span_column;
      logic [7:0]  span_length;
      logic [7:0]  span_colour;
   } rsp_type;

   typedef struct packed {
      logic [11:0]        window_left;
      logic [11:0]        window_top;
      logic [12:0]        window_width;
      logic signed [12:0] sprite_left;
      logic signed [12:0] sprite_top;
      logic [7:0]         sprite_rows;
      logic [7:0]         draw_colour;
   } cfg_type;

   // row-level decode state carried from item to item
   typedef struct packed {
      logic [7:0] row_index;
      logic [6:0] literal_bytes_left;
      logic       sprite_finished;
   } seq_type;

endpackage

[hw/rtl/rle_sprite_double_span_blitter.sv]
// Two register stages: an input register and an output register.
// Throughput: one item per cycle unless a held result stalls the input.
// A held result stalls the input once the input register is also full.
// Reset (synchronous): config cleared to zero, decoder idle until a first byte.
// Depends on rsdsb_pkg, rsdsb_csr and rsdsb_span.
module rle_sprite_double_span_blitter #(
   parameter int COORD_LIMIT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rsdsb_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rsdsb_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsdsb_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rsdsb_pkg::CsrDataWidth-1:0]  csr_data
);
   import rsdsb_pkg::*;

   localparam int COW = $clog2(2 * COORD_LIMIT + 1);

   cfg_type        cfg;
   logic           in_valid_ff;
   logic           in_valid_in;
   req_type        in_item_ff;
   req_type        in_item_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   rsp_type        out_item_ff;
   rsp_type        out_item_in;
   seq_type        seq_ff;
   seq_type        seq_in;
   logic [COW-1:0] col_ff;
   logic [COW-1:0] col_in;
   seq_type        seq_next;
   logic [COW-1:0] col_next;
   logic           span_hit;
   rsp_type        span;
   logic           advance;
   logic           process;

   rsdsb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rsdsb_span #(
      .COORD_LIMIT (COORD_LIMIT)
   ) u_span (
      .item       (in_item_ff),
      .cfg        (cfg),
      .seq        (seq_ff),
      .col_offset (col_ff),
      .seq_next   (seq_next),
      .col_next   (col_next),
      .span_hit   (span_hit),
      .span       (span)
   );

   assign advance   = !out_valid_ff || rsp_ready;
   assign process   = in_valid_ff && advance;
   assign req_ready = !reset && (!in_valid_ff || advance);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      seq_in       = seq_ff;
      col_in       = col_ff;
      if (process) begin
         in_valid_in = 1'b0;
         seq_in      = seq_next;
         col_in      = col_next;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end
      if (advance) begin
         out_valid_in = process && span_hit;
         out_item_in  = span;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         col_ff                 <= '0;
         seq_ff.row_index          <= '0;
         seq_ff.literal_bytes_left <= '0;
         seq_ff.sprite_finished    <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         col_ff       <= col_in;
         seq_ff       <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

endmodule

[hw/rtl/rsdsb_csr.sv]
// Configuration register file for the span blitter.
// Depends on rsdsb_pkg.
module rsdsb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsdsb_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rsdsb_pkg::CsrDataWidth-1:0]  csr_data,
   output rsdsb_pkg::cfg_type                  cfg
);
   import rsdsb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_LEFT:  cfg_in.window_left  = csr_data[11:0];
            CSR_WINDOW_TOP:   cfg_in.window_top   = csr_data[11:0];
            CSR_WINDOW_WIDTH: cfg_in.window_width = csr_data;
            CSR_SPRITE_LEFT:  cfg_in.sprite_left  = $signed(csr_data);
            CSR_SPRITE_TOP:   cfg_in.sprite_top   = $signed(csr_data);
            CSR_SPRITE_ROWS:  cfg_in.sprite_rows  = csr_data[7:0];
            CSR_DRAW_COLOUR:  cfg_in.draw_colour  = csr_data[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/rsdsb_span.sv]
// Per-item decode step: updates row/column state and forms the clipped span.
// Depends on rsdsb_pkg.
module rsdsb_span #(
   parameter int COORD_LIMIT = 4096
) (
   input  rsdsb_pkg::req_type                                 item,
   input  rsdsb_pkg::cfg_type                                 cfg,
   input  rsdsb_pkg::seq_type                                 seq,
   input  logic [$clog2(2*COORD_LIMIT+1)-1:0]                 col_offset,
   output rsdsb_pkg::seq_type                                 seq_next,
   output logic [$clog2(2*COORD_LIMIT+1)-1:0]                 col_next,
   output logic                                               span_hit,
   output rsdsb_pkg::rsp_type                                 span
);
   import rsdsb_pkg::*;

   localparam int ColMax = 2 * COORD_LIMIT;
   localparam int COW    = $clog2(ColMax + 1);
   localparam int SW     = ((COW > 14) ? COW : 14) + 2;

   logic [COW-1:0]       co_eff;
   seq_type              seq_eff;
   logic [8:0]           mag;
   logic [COW:0]         adv_sum;
   logic [COW-1:0]       adv_col;
   logic signed [SW-1:0] start_col;
   logic signed [SW-1:0] stop_col;
   logic signed [SW-1:0] win_lo;
   logic signed [SW-1:0] win_hi;
   logic signed [SW-1:0] clip_lo;
   logic signed [SW-1:0] clip_hi;
   logic signed [SW-1:0] clip_len;
   logic [7:0]           row_inc;

   always_comb begin
      // a first byte restarts the sprite before the byte is decoded
      if (item.first_byte) begin
         co_eff                     = '0;
         seq_eff.row_index          = '0;
         seq_eff.literal_bytes_left = '0;
         seq_eff.sprite_finished    = (cfg.sprite_rows == 8'd0);
      end else begin
         co_eff  = col_offset;
         seq_eff = seq;
      end

      mag = item.code_byte[7] ? (9'd0 - {item.code_byte[7], item.code_byte})
                              : {1'b0, item.code_byte};

      // advance by twice the magnitude, saturating at 2 * COORD_LIMIT
      adv_sum = {1'b0, co_eff} + (COW+1)'({mag, 1'b0});
      adv_col = (adv_sum > (COW+1)'(ColMax)) ? COW'(ColMax) : adv_sum[COW-1:0];

      start_col = $signed({{(SW-12){1'b0}}, cfg.window_left})
                + $signed({{(SW-13){cfg.sprite_left[12]}}, cfg.sprite_left})
                + $signed({{(SW-COW){1'b0}}, co_eff});
      stop_col  = start_col + $signed({{(SW-10){1'b0}}, mag, 1'b0});
      win_lo    = $signed({{(SW-12){1'b0}}, cfg.window_left});
      win_hi    = win_lo + $signed({{(SW-13){1'b0}}, cfg.window_width});
      clip_lo   = (start_col > win_lo) ? start_col : win_lo;
      clip_hi   = (stop_col < win_hi) ? stop_col : win_hi;
      clip_len  = clip_hi - clip_lo;

      row_inc = seq_eff.row_index + 8'd1;

      seq_next = seq_eff;
      col_next = co_eff;
      span_hit = 1'b0;

      if (seq_eff.sprite_finished) begin
         seq_next = seq_eff;
      end else if (seq_eff.row_index >= cfg.sprite_rows) begin
         seq_next.sprite_finished = 1'b1;
      end else if (seq_eff.literal_bytes_left != 7'd0) begin
         seq_next.literal_bytes_left = seq_eff.literal_bytes_left - 7'd1;
      end else if (item.code_byte == 8'sd0) begin
         // end of row
         col_next                    = '0;
         seq_next.row_index          = row_inc;
         seq_next.literal_bytes_left = '0;
         seq_next.sprite_finished    = (row_inc >= cfg.sprite_rows);
      end else if (item.code_byte[7]) begin
         col_next = adv_col;
      end else begin
         // run: the pixel bytes that follow are swallowed
         col_next                    = adv_col;
         seq_next.literal_bytes_left = item.code_byte[6:0];
         span_hit                    = (clip_hi > clip_lo);
      end

      span.span_row    = {1'b0, cfg.window_top} + $unsigned(cfg.sprite_top)
                       + {4'd0, seq_eff.row_index, 1'b0};
      span.span_column = clip_lo[12:0];
      span.span_length = clip_len[7:0];
      span.span_colour = cfg.draw_colour;
   end

endmodule

[hw/rtl/rsdsb_checker.sv]
// Port-level checks for the span blitter, bound to the top level.
// Depends on rsdsb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsdsb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rsdsb_pkg::rsp_type rsp_data
);
   import rsdsb_pkg::*;

   // a fully clipped run never shows up as a span
   `ASSERT_IMPLY(a_len_nonzero, clock, reset, rsp_valid, rsp_data.span_length != 8'd0, "empty span")

   // a run of at most 127 doubled pixels clips to at most 254
   `ASSERT_IMPLY(a_len_max, clock, reset, rsp_valid, rsp_data.span_length <= 8'd254, "span too long")

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // a fresh result comes from an item accepted earlier
   `ASSERT_IMPLY(a_rsp_latency, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without item")

endmodule

bind rle_sprite_double_span_blitter rsdsb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[dv/rsdsb_span_checker.sv]
// Span checker for the double-size run-length sprite span blitter.
// Watches the code-byte, span and register channels, predicts spans and compares them.
// Depends on rsdsb_pkg.
`timescale 1ns / 100ps

module rsdsb_span_checker #(
   parameter int COORD_LIMIT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  rsdsb_pkg::req_type                  req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  rsdsb_pkg::rsp_type                  rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [rsdsb_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rsdsb_pkg::CsrDataWidth-1:0]  csr_data,
   output int                                  mismatch_count,
   output int                                  pending_spans
);

   import rsdsb_pkg::*;

   cfg_type     window_cfg;
   logic [13:0] column_pos;
   logic [7:0]  source_row;
   logic [6:0]  pixel_bytes_left;
   logic        sprite_idle;
   rsp_type     expected_spans[$];
   int          mismatches;

   // column position saturates at 2 * COORD_LIMIT
   function automatic logic [13:0] advanced(input logic [13:0] pos, input int amount);
      int pos_sum;
      pos_sum = int'(pos) + amount;
      if (pos_sum > 2 * COORD_LIMIT) pos_sum = 2 * COORD_LIMIT;
      return pos_sum[13:0];
   endfunction

   task automatic decode_sprite_byte(input req_type item);
      int      code;
      int      start;
      int      stop;
      int      lo;
      int      hi;
      int      row;
      int      len;
      rsp_type span;
      code = $signed(item.code_byte);
      if (item.first_byte) begin
         column_pos       = '0;
         source_row       = '0;
         pixel_bytes_left = '0;
         sprite_idle      = (window_cfg.sprite_rows == 0);
      end
      if (sprite_idle) begin
         // idle until a first byte
      end else if (source_row >= window_cfg.sprite_rows) begin
         sprite_idle = 1'b1;
      end else if (pixel_bytes_left != 0) begin
         pixel_bytes_left--;
      end else if (code == 0) begin
         column_pos = '0;
         source_row++;
         if (source_row >= window_cfg.sprite_rows) sprite_idle = 1'b1;
      end else if (code < 0) begin
         column_pos = advanced(column_pos, -2 * code);
      end else begin
         start = int'(window_cfg.window_left) + int'($signed(window_cfg.sprite_left))
                 + int'(column_pos);
         stop  = start + 2 * code;
         lo    = int'(window_cfg.window_left);
         hi    = int'(window_cfg.window_left) + int'(window_cfg.window_width);
         pixel_bytes_left = code[6:0];
         column_pos = advanced(column_pos, 2 * code);
         if (start > lo) lo = start;
         if (stop < hi) hi = stop;
         if (hi > lo) begin
            row = int'(window_cfg.window_top) + int'($signed(window_cfg.sprite_top))
                  + 2 * int'(source_row);
            len = hi - lo;
            span.span_row    = row[12:0];
            span.span_column = lo[12:0];
            span.span_length = len[7:0];
            span.span_colour = window_cfg.draw_colour;
            expected_spans.push_back(span);
         end
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         window_cfg       = '0;
         column_pos       = '0;
         source_row       = '0;
         pixel_bytes_left = '0;
         sprite_idle      = 1'b1;
         expected_spans.delete();
         mismatches       = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_LEFT:  window_cfg.window_left  = csr_data[11:0];
               CSR_WINDOW_TOP:   window_cfg.window_top   = csr_data[11:0];
               CSR_WINDOW_WIDTH: window_cfg.window_width = csr_data;
               CSR_SPRITE_LEFT:  window_cfg.sprite_left  = csr_data;
               CSR_SPRITE_TOP:   window_cfg.sprite_top   = csr_data;
               CSR_SPRITE_ROWS:  window_cfg.sprite_rows  = csr_data[7:0];
               CSR_DRAW_COLOUR:  window_cfg.draw_colour  = csr_data[7:0];
               default: ;
            endcase
         end
         // spans leave before this edge's item is decoded
         if (rsp_valid && rsp_ready) begin
            if (expected_spans.size() == 0) begin
               $error("span with none expected: row %0d column %0d length %0d",
                      rsp_data.span_row, rsp_data.span_column, rsp_data.span_length);
               mismatches++;
            end else begin
               want = expected_spans.pop_front();
               check_field("span_row", want.span_row, rsp_data.span_row);
               check_field("span_column", want.span_column, rsp_data.span_column);
               check_field("span_length", want.span_length, rsp_data.span_length);
               check_field("span_colour", want.span_colour, rsp_data.span_colour);
            end
         end
         if (req_valid && req_ready) decode_sprite_byte(req_data);
      end
      pending_spans  <= expected_spans.size();
      mismatch_count <= mismatches;
   end

endmodule

[dv/testbench.sv]
// Top of the span blitter testbench: clock, reset, code-byte and register stimulus.
// Instantiates rle_sprite_double_span_blitter and rsdsb_span_checker; uses rsdsb_pkg.
`timescale 1ns / 100ps

module testbench;

   import rsdsb_pkg::*;

   localparam int CoordLimit = 4096;
   localparam int CycleLimit = 300000;

   logic                     clock;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data  = '0;

   int mismatch_count;
   int pending_spans;
   int burst_left  = 0;
   int items_sent  = 0;
   int holds_asked = 0;
   int cycle_count = 0;
   bit start_flag  = 1'b0;

   rle_sprite_double_span_blitter #(
      .COORD_LIMIT(CoordLimit)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rsdsb_span_checker #(
      .COORD_LIMIT(CoordLimit)
   ) span_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_spans  (pending_spans)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // valid stays high across a burst; it drops when a gap starts or in wait_for_spans
   task automatic send_item(input logic [7:0] code, input logic first);
      req_type item;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 9) == 0) ? 30 : $urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      item.code_byte = code;
      item.first_byte = first;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      items_sent++;
   endtask

   // code byte of a sprite; the first one carries the first-byte flag
   task automatic send_code(input logic [7:0] code);
      send_item(code, start_flag);
      start_flag = 1'b0;
   endtask

   task automatic wait_for_spans();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_spans != 0);
      // items with no span may still be in flight
      repeat (4) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_window(input int wl, input int wt, input int ww, input int sl,
                                 input int st, input int rows, input int colour);
      write_reg(CSR_WINDOW_LEFT, wl[12:0]);
      write_reg(CSR_WINDOW_TOP, wt[12:0]);
      write_reg(CSR_WINDOW_WIDTH, ww[12:0]);
      write_reg(CSR_SPRITE_LEFT, sl[12:0]);
      write_reg(CSR_SPRITE_TOP, st[12:0]);
      write_reg(CSR_SPRITE_ROWS, rows[12:0]);
      write_reg(CSR_DRAW_COLOUR, colour[12:0]);
      csr_valid <= 1'b0;
   endtask

   task automatic send_sprite(input int rows, input int max_run);
      int n;
      int kept;
      start_flag = 1'b1;
      for (int r = 0; r < rows; r++) begin
         // long row: skips past the saturation point
         if ($urandom_range(0, 19) == 0) repeat (34) send_code(8'h80);
         repeat ($urandom_range(0, 5)) begin
            if ($urandom_range(0, 9) < 4) begin
               n = $urandom_range(1, 128);
               send_code(8'(-n));
            end else begin
               n = ($urandom_range(0, 39) == 0) ? $urandom_range(1, 127)
                                                : $urandom_range(1, max_run);
               send_code(8'(n));
               // now and then cut the pixel bytes short so the stream slips
               kept = ($urandom_range(0, 11) == 0) ? $urandom_range(0, n - 1) : n;
               repeat (kept) send_code(8'($urandom));
            end
         end
         send_code(8'h00);
      end
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_item(8'($urandom), ($urandom_range(0, 7) == 0));
   endtask

   // receiver: ready pattern changes mode now and then; a long hold when asked
   initial begin
      int mode;
      int mode_left;
      int hold_left;
      int holds_done;
      int tick;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      holds_done = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left = 150;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (tick % 3 != 0);
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) @(posedge clock) cycle_count++;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: decoder idle, then a sprite of zero rows
      send_item(8'd5, 1'b0);
      send_item(8'd3, 1'b1);
      wait_for_spans();

      program_window(100, 50, 200, -10, 5, 3, 8'hA5);
      send_item(8'd1, 1'b1);        // clipped on the left, position moves on
      send_item(8'h7F, 1'b0);
      send_item(-8'sd5, 1'b0);
      send_item(8'd4, 1'b0);
      send_item(8'h00, 1'b0);       // pixel bytes, never codes
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'd127, 1'b0);      // a run of 127, not a pixel byte
      send_item(8'hFF, 1'b0);
      send_item(8'd5, 1'b1);        // restart with pixel bytes pending
      send_item(8'h80, 1'b1);
      send_item(8'h00, 1'b0);
      send_item(-8'sd10, 1'b0);
      send_item(8'd3, 1'b0);
      send_item(8'hAA, 1'b0);
      send_item(8'h55, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b0);       // last row done
      send_item(8'd7, 1'b0);        // ignored
      send_item(8'h00, 1'b1);
      wait_for_spans();
      // row count lowered under the current row
      program_window(100, 50, 200, -10, 5, 1, 8'hA5);
      send_item(8'd2, 1'b0);
      send_item(8'd2, 1'b0);
      wait_for_spans();

      // coordinates at the top of their ranges wrap
      program_window(4095, 4095, 8191, 4095, -4096, 255, 255);
      send_sprite(4, 8);
      wait_for_spans();
      program_window(0, 0, 0, -4096, -4096, 1, 0);
      send_sprite(2, 8);
      wait_for_spans();
      program_window(0, 4095, 4096, -4096, 4095, 2, 8'h81);
      send_sprite(3, 6);
      wait_for_spans();

      // spans every other byte while the receiver holds off
      program_window(0, 10, 4096, 0, 0, 8, 8'h3C);
      holds_asked++;
      start_flag = 1'b1;
      repeat (8) begin
         repeat (6) begin
            send_code(8'd1);
            send_code(8'($urandom));
         end
         send_code(8'h00);
      end
      wait_for_spans();

      while (items_sent < 360) begin
         if ($urandom_range(0, 4) == 0)
            program_window($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
         else
            program_window($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(16, 600), $urandom_range(0, 300) - 100,
                           $urandom_range(0, 8191), $urandom_range(1, 6),
                           $urandom_range(0, 255));
         repeat ($urandom_range(2, 4)) begin
            if ($urandom_range(0, 5) == 0)
               send_noise($urandom_range(3, 12));
            else
               send_sprite($urandom_range(1, 7), $urandom_range(1, 6));
         end
         wait_for_spans();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_spans == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
